/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  // Action codes of an input transaction
  localparam logic [1:0] ACT_ENQ   = 2'd0;
  localparam logic [1:0] ACT_DEQ   = 2'd1;
  localparam logic [1:0] ACT_PEEK  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // Status codes of a result transaction
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int OCC_W = 7;

  // One stored queue entry
  typedef struct packed {
    logic signed [31:0] prio;
    logic [15:0]        tag;
  } entry_t;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] prio_in;
    logic [15:0]        tag_in;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [31:0] prio_out;
    logic [15:0]        tag_out;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } out_t;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctl_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps

// One slot of the sorted chain. Cell 0 holds the lowest priority; priorities
// do not decrease toward higher cells, and among equals the older entry sits
// lower.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               keep_below,
  input  spq_pkg::entry_t    entry_below,
  input  spq_pkg::entry_t    entry_above,
  output spq_pkg::entry_t    entry_q,
  output logic               keep
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Stay put when the stored entry is not above the new one
  assign keep = occupied && !(ctl.ins.prio < entry_r.prio);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      spq_pkg::CELL_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (keep_below) begin
          entry_nxt = ctl.ins;
        end else begin
          entry_nxt = entry_below;
        end
      end
      spq_pkg::CELL_SHIFT: entry_nxt = entry_above;
      default:             entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

/* rtl/sorted_array_priority_queue_unit.sv */
`timescale 1ns / 1ps

// Sorted-array priority queue built as a chain of CAPACITY cells that all
// update in the same cycle: an enqueue compares the new priority against
// every cell in parallel and shifts the higher entries up by one, a dequeue
// shifts the whole chain down by one, so the lowest-priority entry is always
// in cell 0. Equal priorities leave in arrival order. Every transaction
// (enqueue, dequeue, peek, clear) yields exactly one result in a registered
// output stage; a new transaction is accepted in every cycle in which the
// result register is empty or is being taken. Enqueue into a full queue
// reports status full and leaves the queue unchanged; dequeue or peek on
// an empty queue reports status empty. No clearing pass after reset.
module sorted_array_priority_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output spq_pkg::out_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  spq_pkg::out_t      out_data_r;
  spq_pkg::out_t      res;
  spq_pkg::cell_ctl_t ctl;
  logic               fire;
  logic               full;
  logic               empty;

  spq_pkg::entry_t    entry_q [CAPACITY];
  logic               keep    [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  // Decode the transaction into a chain operation and a result
  always_comb begin
    ctl.op       = spq_pkg::CELL_HOLD;
    ctl.ins.prio = in_data.prio_in;
    ctl.ins.tag  = in_data.tag_in;
    count_nxt    = count_r;
    res.prio_out = '0;
    res.tag_out  = '0;
    res.status   = spq_pkg::ST_OK;
    unique case (in_data.action)
      spq_pkg::ACT_ENQ: begin
        if (full) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          ctl.op    = spq_pkg::CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      spq_pkg::ACT_DEQ: begin
        if (empty) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          ctl.op       = spq_pkg::CELL_SHIFT;
          count_nxt    = count_r - 1'b1;
          res.prio_out = entry_q[0].prio;
          res.tag_out  = entry_q[0].tag;
        end
      end
      spq_pkg::ACT_PEEK: begin
        if (empty) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.prio_out = entry_q[0].prio;
          res.tag_out  = entry_q[0].tag;
        end
      end
      default: count_nxt = '0;
    endcase
    if (!fire) begin
      ctl.op    = spq_pkg::CELL_HOLD;
      count_nxt = count_r;
    end
    res.occupancy = spq_pkg::OCC_W'(count_nxt);
  end

  // Chain of cells
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic            occ;
    logic            kb;
    spq_pkg::entry_t eb;
    spq_pkg::entry_t ea;

    assign occ = (CNT_W'(j) < count_r);

    if (j == 0) begin : g_first
      assign kb = 1'b1;
      assign eb = ctl.ins;
    end else begin : g_mid
      assign kb = keep[j-1];
      assign eb = entry_q[j-1];
    end

    if (j == CAPACITY - 1) begin : g_last
      assign ea = entry_q[j];
    end else begin : g_up
      assign ea = entry_q[j+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .keep_below  (kb),
      .entry_below (eb),
      .entry_above (ea),
      .entry_q     (entry_q[j]),
      .keep        (keep[j])
    );
  end

  // Count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.action == spq_pkg::ACT_ENQ && !full
    |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("enqueue did not grow the queue");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.action == spq_pkg::ACT_CLEAR |=> count_r == '0)
    else $error("clear left entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.action == spq_pkg::ACT_ENQ && full
    |=> out_valid_r && out_data_r.status == spq_pkg::ST_FULL && $stable(count_r))
    else $error("full enqueue not reported or queue changed");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("fill count changed without a transaction");
`endif

endmodule

/* tb/sv/tb_sorted_array_priority_queue_unit.sv */
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue_unit;

  localparam int CAPACITY = 64;

  // One queued stimulus transaction with its pacing controls
  typedef struct {
    spq_pkg::in_t data;
    int unsigned  gap_after;   // idle cycles after this one is accepted
    bit           drain_first; // wait for all results before offering
    bit           rx_hold;     // start a long receiver hold-off when offered
  } op_req_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  spq_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  spq_pkg::out_t out_data;

  op_req_t         pending_ops[$];
  spq_pkg::out_t   expected_results[$];
  spq_pkg::entry_t queue_model[$];   // slot 0 holds the highest priority
  int unsigned     outstanding_cnt = 0;
  int unsigned     err_count = 0;
  logic            hold_req = 1'b0;
  bit              tx_idle = 1'b1;

  sorted_array_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Queue model: applies one transaction and returns its result
  function automatic spq_pkg::out_t predict_result(spq_pkg::in_t op);
    spq_pkg::out_t res;
    int            pos;
    res = '0;
    res.status = spq_pkg::ST_OK;
    case (op.action)
      spq_pkg::ACT_ENQ: begin
        if (queue_model.size() >= CAPACITY) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // new item goes ahead of every entry with lower or equal priority
          pos = queue_model.size();
          for (int i = 0; i < queue_model.size(); i++) begin
            if ($signed(op.prio_in) >= $signed(queue_model[i].prio)) begin
              pos = i;
              break;
            end
          end
          queue_model.insert(pos, '{prio: op.prio_in, tag: op.tag_in});
        end
      end
      spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK: begin
        if (queue_model.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.prio_out = queue_model[$].prio;
          res.tag_out  = queue_model[$].tag;
          if (op.action == spq_pkg::ACT_DEQ) void'(queue_model.pop_back());
        end
      end
      default: begin
        queue_model.delete();
      end
    endcase
    res.occupancy = spq_pkg::OCC_W'(queue_model.size());
    return res;
  endfunction

  // Priority mix: full range, a narrow band for ties, the extremes, and zero or minus one
  function automatic logic signed [31:0] rand_prio();
    logic signed [31:0] p;
    case ($urandom_range(0, 5))
      0, 1: p = $urandom;
      2, 3: p = int'($urandom_range(0, 8)) - 4;
      4:    p = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: p = $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
    endcase
    return p;
  endfunction

  task automatic add_op(input logic [1:0] act, input logic signed [31:0] prio,
                        input logic [15:0] tag, input bit drain, input bit hold);
    op_req_t r;
    r.data.action  = act;
    r.data.prio_in = prio;
    r.data.tag_in  = tag;
    r.gap_after    = tx_idle ? $urandom_range(0, 7) : 0;
    r.drain_first  = drain;
    r.rx_hold      = hold;
    pending_ops.push_back(r);
  endtask

  task automatic add_random_op();
    logic [1:0]  act;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 48)      act = spq_pkg::ACT_ENQ;
    else if (r < 78) act = spq_pkg::ACT_DEQ;
    else if (r < 95) act = spq_pkg::ACT_PEEK;
    else             act = spq_pkg::ACT_CLEAR;
    add_op(act, rand_prio(), 16'($urandom), 1'b0, 1'b0);
  endtask

  // Stimulus: directed part, then random sequences
  initial begin
    int unsigned n_deq;
    int unsigned run_len;
    int unsigned next_drain;
    int unsigned next_toggle;

    // empty queue first, with all-ones noise in the unused fields
    add_op(spq_pkg::ACT_DEQ,   32'shffffffff, 16'hffff, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_PEEK,  32'sh0,        16'h0000, 1'b0, 1'b0);
    // extremes and ties
    add_op(spq_pkg::ACT_ENQ,   32'sh7fffffff, 16'hffff, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   32'sh80000000, 16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   32'sh0,        16'h5a5a, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   -32'sh1,       16'ha5a5, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   32'sh5,        16'h0001, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   32'sh5,        16'h0002, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   32'sh5,        16'h0003, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_PEEK,  32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_PEEK,  32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_ENQ,   32'sh7fffffff, 16'h0007, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    // clear on a non-empty queue, then on an empty one
    add_op(spq_pkg::ACT_CLEAR, 32'sh12345678, 16'hbeef, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_DEQ,   32'sh0,        16'h0000, 1'b0, 1'b0);
    add_op(spq_pkg::ACT_CLEAR, 32'sh0,        16'h0000, 1'b0, 1'b0);

    // long receiver hold-off while the sender keeps offering back to back,
    // run into a full queue with enqueues past capacity
    tx_idle = 1'b0;
    add_op(spq_pkg::ACT_CLEAR, rand_prio(), 16'($urandom), 1'b1, 1'b1);
    repeat (CAPACITY + 3)
      add_op(spq_pkg::ACT_ENQ, rand_prio(), 16'($urandom), 1'b0, 1'b0);
    add_op(spq_pkg::ACT_PEEK, rand_prio(), 16'($urandom), 1'b0, 1'b0);
    repeat (CAPACITY + 2)
      add_op(spq_pkg::ACT_DEQ, rand_prio(), 16'($urandom), 1'b0, 1'b0);
    tx_idle = 1'b1;

    next_drain  = pending_ops.size() + 300;
    next_toggle = pending_ops.size() + 150;
    while (pending_ops.size() < 1100) begin
      if ($urandom_range(0, 9) < 2) begin
        // well-formed fill: clear, fill near or past capacity, peek, drain none, some or all
        add_op(spq_pkg::ACT_CLEAR, rand_prio(), 16'($urandom), 1'b0, 1'b0);
        repeat ($urandom_range(CAPACITY - 4, CAPACITY + 3))
          add_op(spq_pkg::ACT_ENQ, rand_prio(), 16'($urandom), 1'b0, 1'b0);
        add_op(spq_pkg::ACT_PEEK, rand_prio(), 16'($urandom), 1'b0, 1'b0);
        n_deq = $urandom_range(0, CAPACITY + 4);
        repeat (n_deq)
          add_op(spq_pkg::ACT_DEQ, rand_prio(), 16'($urandom), 1'b0, 1'b0);
      end else begin
        run_len = $urandom_range(20, 40);
        repeat (run_len) add_random_op();
      end
      if (pending_ops.size() >= next_drain) begin
        // sender pauses until every result is back
        add_op(spq_pkg::ACT_PEEK, rand_prio(), 16'($urandom), 1'b1, 1'b0);
        next_drain = pending_ops.size() + 300;
      end
      if (pending_ops.size() >= next_toggle) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        next_toggle = pending_ops.size() + 150;
      end
    end

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the stimulus to run out and every result to arrive,
    // sampled between edges so the driver's updates have settled
    @(posedge clk);
    while (!(pending_ops.size() == 0 && !in_valid && outstanding_cnt == 0))
      @(negedge clk);
    repeat (20) @(posedge clk);

    if (expected_results.size() != 0)
      $display("%0d expected results never arrived", expected_results.size());
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: offers pending transactions with per-item gaps
  int unsigned gap_cnt = 0;
  always @(posedge clk) begin
    logic         nv;
    spq_pkg::in_t nd;
    logic         nh;
    op_req_t      r;
    nv = in_valid;
    nd = in_data;
    nh = 1'b0;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) nv = 1'b0;
      if (!nv) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (pending_ops.size() != 0) begin
          // a drain point waits until no result is owed
          if (!pending_ops[0].drain_first ||
              (outstanding_cnt == 0 && !(in_valid && in_ready))) begin
            r = pending_ops.pop_front();
            nv = 1'b1;
            nd = r.data;
            nh = r.rx_hold;
            gap_cnt = r.gap_after;
          end
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
    hold_req <= nh;
  end

  // Receiver: random stalls per result, idle-free stretches, one long hold-off
  int unsigned stall_cnt = 0;
  int unsigned hold_cnt = 0;
  int unsigned rx_cycles = 0;
  bit          rx_idle = 1'b1;
  always @(posedge clk) begin
    logic nr;
    if (!rst_n) begin
      nr = 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 256 == 0) rx_idle = ($urandom_range(0, 3) != 0);
      if (out_valid && out_ready) stall_cnt = rx_idle ? $urandom_range(0, 7) : 0;
      else if (stall_cnt != 0) stall_cnt--;
      if (hold_req) hold_cnt = 300;
      else if (hold_cnt != 0) hold_cnt--;
      nr = (stall_cnt == 0) && (hold_cnt == 0);
    end
    out_ready <= nr;
  end

  // Monitor: checks each result against the oldest prediction, then
  // predicts the transaction accepted at this edge
  always @(posedge clk) begin
    spq_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("Unexpected result: prio %0d tag %h status %0d occ %0d",
                     out_data.prio_out, out_data.tag_out, out_data.status,
                     out_data.occupancy);
        end else begin
          want = expected_results.pop_front();
          if (out_data.prio_out !== want.prio_out || out_data.tag_out !== want.tag_out ||
              out_data.status !== want.status || out_data.occupancy !== want.occupancy) begin
            err_count++;
            if (err_count <= 10)
              $display({"Mismatch: expected prio %0d tag %h status %0d occ %0d,",
                        " got prio %0d tag %h status %0d occ %0d"},
                       want.prio_out, want.tag_out, want.status, want.occupancy,
                       out_data.prio_out, out_data.tag_out, out_data.status,
                       out_data.occupancy);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
    end
    outstanding_cnt <= expected_results.size();
  end

endmodule
